// ----- rtl/core/kma_pkg.sv -----
`default_nettype none
package kma_pkg;
    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int MAX_POINTS_DEF = 65536;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    localparam logic REG_CLUSTER_COUNT = 1'b0;
    localparam logic REG_TOLERANCE_SQ = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_POINT = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_ACC,
        ST_PRES,
        ST_FRD,
        ST_DIV,
        ST_DIVN,
        ST_DISP,
        ST_FRES,
        ST_CLR
    } state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [3:0] prior;
    } item_t;

    typedef struct packed {
        logic [2:0] cluster;
        logic changed;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_z;
        logic empty_res;
        logic converged;
        logic last;
    } result_t;

    localparam int ITEM_W = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (s < -33'sh080000000) return 32'sh80000000;
        return s[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/kma_ram.sv -----
`default_nettype none
module kma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire                           clk,
    input  wire                           we,
    input  wire [$clog2(DEPTH+1)-1:0]     waddr,
    input  wire [WIDTH-1:0]               wdata,
    input  wire [$clog2(DEPTH+1)-1:0]     raddr,
    output logic [WIDTH-1:0]              rdata
);
    localparam int AW = $clog2(DEPTH+1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we && waddr < AW'(DEPTH))
        begin
            mem[IW'(waddr)] <= wdata;
        end
        rdata <= mem[(raddr < AW'(DEPTH)) ? IW'(raddr) : IW'(0)];
    end
endmodule
`default_nettype wire

// ----- rtl/core/kma_fifo.sv -----
`default_nettype none
module kma_fifo #(
    parameter int WIDTH = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  din,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] dout,
    output logic             nempty
);
    logic [WIDTH-1:0] data_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    assign full = cnt_reg == 2'd2;
    assign nempty = cnt_reg != 2'd0;
    assign dout = data_reg[rp_reg];
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            data_reg[wp_reg] <= din;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && nempty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && nempty);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/kma_div.sv -----
`default_nettype none
module kma_div (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire signed [31:0] dividend,
    input  wire [16:0]        divisor,
    output logic              done,
    output logic signed [15:0] quot
);
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [16:0] d_reg;
    logic neg_reg, busy_reg;
    logic [5:0] n_reg;
    logic [32:0] trial;
    logic signed [33:0] sq;

    always_comb
    begin
        trial = {r_reg[31:0], q_reg[31]};
        r_next = trial;
        q_next = {q_reg[30:0], 1'b0};
        if (trial >= 33'(d_reg))
        begin
            r_next = trial - 33'(d_reg);
            q_next[0] = 1'b1;
        end
        sq = neg_reg ? -34'(q_reg) : 34'(q_reg);
        if (sq > 34'sd32767) quot = 16'sh7FFF;
        else if (sq < -34'sd32768) quot = 16'sh8000;
        else quot = sq[15:0];
    end

    assign done = busy_reg && n_reg == 6'd32;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend[31] ? 32'(-33'(dividend)) : dividend;
            r_reg <= '0;
            d_reg <= divisor;
            neg_reg <= dividend[31];
        end
        else if (busy_reg && n_reg != 6'd32)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg + 6'd1;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/kma_back.sv -----
`default_nettype none
module kma_back #(
    parameter int MAX_CLUSTERS = kma_pkg::MAX_CLUSTERS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire [3:0]             cluster_count,
    input  wire [31:0]            tolerance_sq,
    input  wire                   q_nempty,
    input  wire kma_pkg::item_t   q_item,
    output logic                  q_pop,
    output logic                  o_valid,
    output kma_pkg::result_t      o_res,
    input  wire                   o_stall
);
    localparam int AW = $clog2(MAX_CLUSTERS+1);
    localparam int KW = (AW > 4) ? AW : 4;

    kma_pkg::state_t st_reg, st_next;
    kma_pkg::item_t it_reg;
    logic [AW-1:0] j_reg, best_reg;
    logic [49:0] bd_reg;
    logic [49:0] md_reg;
    logic [1:0] ax_reg;
    logic signed [15:0] nq_reg [3];
    logic ov_reg;
    kma_pkg::result_t or_reg;
    logic [KW-1:0] kk;
    logic [AW-1:0] k;
    logic [AW-1:0] last_j;

    logic [47:0] cr, cw;
    logic cwe;
    logic [AW-1:0] craddr, cwaddr, araddr, awaddr;
    logic [112:0] ar, aw;
    logic awe;

    kma_ram #(.WIDTH(48), .DEPTH(MAX_CLUSTERS)) u_cent (
        .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cw), .raddr(craddr), .rdata(cr));
    kma_ram #(.WIDTH(113), .DEPTH(MAX_CLUSTERS)) u_acc (
        .clk(clk), .we(awe), .waddr(awaddr), .wdata(aw), .raddr(araddr), .rdata(ar));

    logic signed [15:0] cx, cy, cz;
    logic signed [31:0] sx, sy, sz;
    logic [16:0] cnt;
    assign cx = cr[47:32];
    assign cy = cr[31:16];
    assign cz = cr[15:0];
    assign sx = ar[112:81];
    assign sy = ar[80:49];
    assign sz = ar[48:17];
    assign cnt = ar[16:0];

    logic signed [16:0] dx, dy, dz, ex, ey, ez;
    logic [49:0] d3, e3;
    always_comb
    begin
        dx = 17'(it_reg.x) - 17'(cx);
        dy = 17'(it_reg.y) - 17'(cy);
        dz = 17'(it_reg.z) - 17'(cz);
        d3 = 50'(34'(dx * dx)) + 50'(34'(dy * dy)) + 50'(34'(dz * dz));
        ex = 17'(nq_reg[0]) - 17'(cx);
        ey = 17'(nq_reg[1]) - 17'(cy);
        ez = 17'(nq_reg[2]) - 17'(cz);
        e3 = 50'(34'(ex * ex)) + 50'(34'(ey * ey)) + 50'(34'(ez * ez));
    end

    logic dv_start, dv_done;
    logic signed [31:0] dv_a;
    logic signed [15:0] dv_q;
    kma_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
        .divisor(cnt), .done(dv_done), .quot(dv_q));
    always_comb
    begin
        case (ax_reg)
            2'd0: dv_a = sx;
            2'd1: dv_a = sy;
            default: dv_a = sz;
        endcase
    end

    always_comb
    begin
        kk = KW'(cluster_count);
        if (kk == '0) kk = KW'(1);
        if (kk > KW'(MAX_CLUSTERS)) kk = KW'(MAX_CLUSTERS);
        k = AW'(kk);
        last_j = k - AW'(1);
    end

    logic out_free;
    logic load_out;
    assign out_free = !ov_reg || !o_stall;
    assign load_out = (st_reg == kma_pkg::ST_PRES || st_reg == kma_pkg::ST_FRES) && out_free;
    assign o_valid = ov_reg;
    assign o_res = or_reg;

    kma_pkg::result_t pres, fres;
    always_comb
    begin
        pres = '0;
        pres.cluster = 3'(best_reg);
        pres.changed = it_reg.prior != 4'(best_reg);
        pres.last = 1'b1;
        fres = '0;
        fres.cluster = 3'(j_reg);
        fres.new_x = (cnt == '0) ? cx : nq_reg[0];
        fres.new_y = (cnt == '0) ? cy : nq_reg[1];
        fres.new_z = (cnt == '0) ? cz : nq_reg[2];
        fres.empty_res = cnt == '0;
        fres.converged = (j_reg == last_j) && (md_reg <= 50'(tolerance_sq));
        fres.last = j_reg == last_j;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            kma_pkg::ST_IDLE:
                if (q_nempty)
                begin
                    unique case (q_item.opcode)
                        kma_pkg::OP_POINT: st_next = kma_pkg::ST_DIST;
                        kma_pkg::OP_FINISH: st_next = kma_pkg::ST_FRD;
                        default: st_next = kma_pkg::ST_IDLE;
                    endcase
                end
            kma_pkg::ST_DIST:
                if (j_reg == last_j) st_next = kma_pkg::ST_ACC;
            kma_pkg::ST_ACC: st_next = kma_pkg::ST_PRES;
            kma_pkg::ST_PRES:
                if (out_free) st_next = kma_pkg::ST_IDLE;
            kma_pkg::ST_FRD:
                st_next = (cnt == '0) ? kma_pkg::ST_FRES : kma_pkg::ST_DIV;
            kma_pkg::ST_DIV: st_next = kma_pkg::ST_DIVN;
            kma_pkg::ST_DIVN:
                if (dv_done) st_next = (ax_reg == 2'd2) ? kma_pkg::ST_DISP : kma_pkg::ST_DIV;
            kma_pkg::ST_DISP: st_next = kma_pkg::ST_FRES;
            kma_pkg::ST_FRES:
                if (out_free) st_next = (j_reg == last_j) ? kma_pkg::ST_CLR : kma_pkg::ST_FRD;
            kma_pkg::ST_CLR:
                if (j_reg == AW'(MAX_CLUSTERS - 1)) st_next = kma_pkg::ST_IDLE;
            default: st_next = kma_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        cwe = 1'b0;
        cwaddr = j_reg;
        cw = {it_reg.x, it_reg.y, it_reg.z};
        craddr = j_reg;
        araddr = j_reg;
        awe = 1'b0;
        awaddr = best_reg;
        aw = {kma_pkg::sat_add(sx, it_reg.x), kma_pkg::sat_add(sy, it_reg.y),
              kma_pkg::sat_add(sz, it_reg.z),
              (cnt == kma_pkg::COUNT_MAX) ? cnt : cnt + 17'd1};
        dv_start = 1'b0;
        unique case (st_reg)
            kma_pkg::ST_IDLE:
            begin
                q_pop = q_nempty;
                craddr = '0;
                araddr = '0;
                if (q_nempty && q_item.opcode == kma_pkg::OP_LOAD)
                begin
                    cwe = 1'b1;
                    cwaddr = (int'(q_item.slot) < MAX_CLUSTERS)
                        ? AW'(q_item.slot) : AW'(MAX_CLUSTERS);
                    cw = {q_item.x, q_item.y, q_item.z};
                end
            end
            kma_pkg::ST_DIST:
            begin
                craddr = j_reg + AW'(1);
                araddr = best_reg;
            end
            kma_pkg::ST_ACC:
            begin
                araddr = best_reg;
            end
            kma_pkg::ST_PRES:
            begin
                araddr = best_reg;
                awe = out_free;
            end
            kma_pkg::ST_DIV: dv_start = 1'b1;
            kma_pkg::ST_DISP:
            begin
                cwe = 1'b1;
                cwaddr = j_reg;
                cw = {nq_reg[0], nq_reg[1], nq_reg[2]};
            end
            kma_pkg::ST_FRES:
            begin
                craddr = out_free ? j_reg + AW'(1) : j_reg;
                araddr = out_free ? j_reg + AW'(1) : j_reg;
            end
            kma_pkg::ST_CLR:
            begin
                awe = 1'b1;
                awaddr = j_reg;
                aw = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == kma_pkg::ST_IDLE && q_nempty)
        begin
            it_reg <= q_item;
        end
        if (st_reg == kma_pkg::ST_DIST)
        begin
            if (j_reg == '0 || d3 < bd_reg)
            begin
                bd_reg <= d3;
                best_reg <= j_reg;
            end
        end
        if (st_reg == kma_pkg::ST_IDLE)
        begin
            best_reg <= '0;
            md_reg <= '0;
        end
        if (st_reg == kma_pkg::ST_FRD) ax_reg <= 2'd0;
        if (st_reg == kma_pkg::ST_DIVN && dv_done)
        begin
            nq_reg[ax_reg] <= dv_q;
            ax_reg <= ax_reg + 2'd1;
        end
        if (st_reg == kma_pkg::ST_DISP && e3 > md_reg) md_reg <= e3;
        if (st_reg == kma_pkg::ST_PRES && out_free)
        begin
            or_reg <= pres;
        end
        else if (st_reg == kma_pkg::ST_FRES && out_free)
        begin
            or_reg <= fres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= kma_pkg::ST_CLR;
            j_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (load_out) ov_reg <= 1'b1;
            else if (!o_stall) ov_reg <= 1'b0;
            unique case (st_reg)
                kma_pkg::ST_IDLE: j_reg <= '0;
                kma_pkg::ST_DIST:
                    j_reg <= (j_reg == last_j) ? j_reg : j_reg + AW'(1);
                kma_pkg::ST_FRES:
                    if (out_free) j_reg <= (j_reg == last_j) ? '0 : j_reg + AW'(1);
                kma_pkg::ST_CLR:
                    j_reg <= (j_reg == AW'(MAX_CLUSTERS - 1)) ? '0 : j_reg + AW'(1);
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/kmeans_assign_and_update_core.sv -----
`default_nettype none
// channel | direction | handshake         | payload
// in      | to block  | in_valid/in_stall | opcode slot coord_x/y/z prior_cluster
// out     | from block| out_valid/out_stall | cluster changed new_x/y/z empty_res converged last
// cfg     | to block  | cfg_valid/cfg_ready | cfg_index cfg_data
// A point is handled in order: pop, one centroid distance per cycle, accumulator read, write.
// A finish runs three 32-step serial divides per non-empty cluster and none for an empty one,
// then clears the accumulators; out_stall holds it while asserted.
// After reset the accumulator RAM is cleared; the queue takes two items.
// A two-entry queue decouples input acceptance from the back end; out holds under out_stall.
module kmeans_assign_and_update_core #(
    parameter int MAX_CLUSTERS = kma_pkg::MAX_CLUSTERS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire [1:0]         opcode,
    input  wire [2:0]         slot,
    input  wire signed [15:0] coord_x,
    input  wire signed [15:0] coord_y,
    input  wire signed [15:0] coord_z,
    input  wire [3:0]         prior_cluster,
    output logic              out_valid,
    input  wire               out_stall,
    output logic [2:0]        cluster,
    output logic              changed,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y,
    output logic signed [15:0] new_z,
    output logic              empty_res,
    output logic              converged,
    output logic              last,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire               cfg_index,
    input  wire [31:0]        cfg_data
);
    logic [3:0] cc_reg;
    logic [31:0] tol_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= 4'd8;
            tol_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == kma_pkg::REG_CLUSTER_COUNT) cc_reg <= cfg_data[3:0];
            else tol_reg <= cfg_data;
        end
    end

    kma_pkg::item_t in_item, q_item;
    logic full, q_pop, q_nempty;
    assign in_item = {opcode, slot, coord_x, coord_y, coord_z, prior_cluster};
    assign in_stall = full;
    kma_fifo #(.WIDTH(kma_pkg::ITEM_W)) u_q (
        .clk(clk), .rst_n(rst_n), .push(in_valid), .din(in_item), .full(full),
        .pop(q_pop), .dout(q_item), .nempty(q_nempty));

    kma_pkg::result_t res;
    kma_back #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_back (
        .clk(clk), .rst_n(rst_n), .cluster_count(cc_reg), .tolerance_sq(tol_reg),
        .q_nempty(q_nempty), .q_item(q_item), .q_pop(q_pop),
        .o_valid(out_valid), .o_res(res), .o_stall(out_stall));
    assign cluster = res.cluster;
    assign changed = res.changed;
    assign new_x = res.new_x;
    assign new_y = res.new_y;
    assign new_z = res.new_z;
    assign empty_res = res.empty_res;
    assign converged = res.converged;
    assign last = res.last;
endmodule
`default_nettype wire
